[rtl/bpa_pkg.sv]
// Shared types and constants for the bitmap page allocator.
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int CMD_W     = 2;
   localparam int ADDR_W    = 32;
   localparam int LIMIT_W   = 13;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;

   localparam logic [ADDR_W-1:0]  BASE_RESET  = 32'd4096;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC   = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_MARK    = 2'd2
   } cmd_type;

   typedef enum logic {
      REG_BASE  = 1'b0,
      REG_LIMIT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  page_base;
      logic [LIMIT_W-1:0] page_limit;
   } cfg_type;

endpackage

[rtl/bpa_if.sv]
// Request and response channel interfaces of the bitmap page allocator.
`timescale 1ns / 1ps

interface bpa_req_if;
   logic                       valid;
   logic                       ready;
   logic [bpa_pkg::CMD_W-1:0]  command;
   logic [bpa_pkg::ADDR_W-1:0] page_address;

   modport source (output valid, output command, output page_address, input ready);
   modport sink   (input valid, input command, input page_address, output ready);
endinterface

interface bpa_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [bpa_pkg::ADDR_W-1:0] result_address;
   logic                       success;

   modport source (output valid, output result_address, output success, input ready);
   modport sink   (input valid, input result_address, input success, output ready);
endinterface

[rtl/bpa_bitmap_ram.sv]
// Bitmap word memory: one write port, one registered read port.
`timescale 1ns / 1ps

module bpa_bitmap_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [31:0]       rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [31:0]       wr_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/bpa_csr.sv]
// APB configuration registers: base address and page limit.
`timescale 1ns / 1ps

module bpa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bpa_pkg::PDATA_W-1:0]  pwdata,
   output logic [bpa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output bpa_pkg::cfg_type             cfg
);

   bpa_pkg::cfg_type       cfg_ff;
   bpa_pkg::cfg_type       cfg_in;
   bpa_pkg::reg_index_type reg_sel;
   logic                   wr_stb;

   assign pready  = 1'b1;
   assign reg_sel = bpa_pkg::reg_index_type'(paddr[2]);
   assign wr_stb  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            bpa_pkg::REG_BASE:  cfg_in.page_base  = pwdata;
            bpa_pkg::REG_LIMIT: cfg_in.page_limit = pwdata[bpa_pkg::LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         bpa_pkg::REG_BASE:  prdata = cfg_ff.page_base;
         bpa_pkg::REG_LIMIT: prdata = bpa_pkg::PDATA_W'(cfg_ff.page_limit);
         default:            prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.page_base  <= bpa_pkg::BASE_RESET;
         cfg_ff.page_limit <= bpa_pkg::LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/bpa_ctrl.sv]
// Command sequencer: bitmap clear, first-fit scan and read-modify-write.
`timescale 1ns / 1ps

module bpa_ctrl #(
   parameter int BITMAP_WORDS = 128,
   parameter int PAGE_SHIFT   = 12,
   parameter int AW           = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  bpa_pkg::cfg_type       cfg,
   bpa_req_if.sink                req_chan,
   bpa_rsp_if.source              rsp_chan,
   output logic                   ram_rd_en,
   output logic [AW-1:0]          ram_rd_addr,
   input  logic [31:0]            ram_rd_data,
   output logic                   ram_wr_en,
   output logic [AW-1:0]          ram_wr_addr,
   output logic [31:0]            ram_wr_data
);

   localparam int IDX_W = AW + 5;
   localparam int LIM_W = IDX_W + 1;
   localparam int TOTAL = BITMAP_WORDS * 32;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_INDEX,
      ST_MODIFY,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [bpa_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [31:0]                 offset_ff, offset_in;
   logic [AW:0]                 scan_w_ff, scan_w_in;
   logic [AW-1:0]               chk_w_ff, chk_w_in;
   logic                        chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   logic                        ok_ff, ok_in;
   logic [AW-1:0]               clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [31:0]                 rsp_addr_ff, rsp_addr_in;
   logic                        rsp_ok_ff, rsp_ok_in;

   logic [LIM_W-1:0]            eff_lim;
   logic [LIM_W-1:0]            scan_start;
   logic [LIM_W-1:0]            chk_start;
   logic [LIM_W-1:0]            rem;
   logic [31:0]                 valid_mask;
   logic [31:0]                 free_bits;
   logic                        found;
   logic [4:0]                  pos;
   logic [31:0]                 idx32;
   logic                        in_range;
   logic [31:0]                 bit_sel;

   always_comb begin
      if (32'(cfg.page_limit) < 32'(TOTAL)) begin
         eff_lim = LIM_W'(cfg.page_limit);
      end else begin
         eff_lim = LIM_W'(TOTAL);
      end
   end

   assign scan_start = {scan_w_ff, 5'd0};
   assign chk_start  = {1'b0, chk_w_ff, 5'd0};
   assign rem        = eff_lim - chk_start;

   always_comb begin
      if (rem >= LIM_W'(32)) begin
         valid_mask = '1;
      end else begin
         valid_mask = (32'd1 << rem[4:0]) - 32'd1;
      end
   end

   assign free_bits = ~ram_rd_data & valid_mask;
   assign found     = |free_bits;

   always_comb begin
      pos = '0;
      for (int i = 31; i >= 0; i--) begin
         if (free_bits[i]) begin
            pos = 5'(i);
         end
      end
   end

   assign idx32    = offset_ff >> PAGE_SHIFT;
   assign in_range = idx32 < 32'(eff_lim);
   assign bit_sel  = 32'd1 << idx_ff[4:0];

   // Each write lands before the next command issues its read, so no forwarding.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      offset_in    = offset_ff;
      scan_w_in    = scan_w_ff;
      chk_w_in     = chk_w_ff;
      chk_vld_in   = chk_vld_ff;
      idx_in       = idx_ff;
      ok_in        = ok_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_addr_in  = rsp_addr_ff;
      rsp_ok_in    = rsp_ok_ff;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_data  = '0;
      req_chan.ready = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + AW'(1);
            if (clr_ff == AW'(BITMAP_WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               cmd_in     = req_chan.command;
               offset_in  = req_chan.page_address - cfg.page_base;
               scan_w_in  = '0;
               chk_vld_in = 1'b0;
               ok_in      = 1'b0;
               unique case (req_chan.command) inside
                  bpa_pkg::CMD_ALLOC:                     state_in = ST_SCAN;
                  bpa_pkg::CMD_RELEASE, bpa_pkg::CMD_MARK: state_in = ST_INDEX;
                  default:                                state_in = ST_DONE;
               endcase
            end
         end
         ST_SCAN: begin
            if (chk_vld_ff && found) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = chk_w_ff;
               ram_wr_data = ram_rd_data | (32'd1 << pos);
               idx_in      = {chk_w_ff, pos};
               ok_in       = 1'b1;
               chk_vld_in  = 1'b0;
               state_in    = ST_DONE;
            end else if (scan_start < eff_lim) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = scan_w_ff[AW-1:0];
               chk_w_in    = scan_w_ff[AW-1:0];
               chk_vld_in  = 1'b1;
               scan_w_in   = scan_w_ff + (AW+1)'(1);
            end else begin
               chk_vld_in = 1'b0;
               state_in   = ST_DONE;
            end
         end
         ST_INDEX: begin
            idx_in = idx32[IDX_W-1:0];
            if (in_range) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx32[IDX_W-1:5];
               state_in    = ST_MODIFY;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MODIFY: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff[IDX_W-1:5];
            if (cmd_ff == bpa_pkg::CMD_RELEASE) begin
               ram_wr_data = ram_rd_data & ~bit_sel;
            end else begin
               ram_wr_data = ram_rd_data | bit_sel;
            end
            ok_in    = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = ok_ff;
               if (ok_ff && cmd_ff == bpa_pkg::CMD_ALLOC) begin
                  rsp_addr_in = cfg.page_base + (32'(idx_ff) << PAGE_SHIFT);
               end else begin
                  rsp_addr_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         cmd_ff       <= cmd_in;
         offset_ff    <= offset_in;
         scan_w_ff    <= scan_w_in;
         chk_w_ff     <= chk_w_in;
         idx_ff       <= idx_in;
         ok_ff        <= ok_in;
         rsp_addr_ff  <= rsp_addr_in;
         rsp_ok_ff    <= rsp_ok_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_address = rsp_addr_ff;
   assign rsp_chan.success        = rsp_ok_ff;

endmodule

[rtl/bitmap_page_allocator.sv]
// Bitmap page allocator top level.
// Allocate: bitmap words are read from word 0 up to the page limit, one word read per cycle;
// the lowest free bit of the first word that has one is set and the result is registered.
// Release / mark in use: ST_INDEX reads the word, ST_MODIFY writes it, ST_DONE registers
// the result; out of range skips ST_MODIFY, an unused command goes straight to ST_DONE.
// A new request is taken while a result waits; after reset all words are cleared first.
`timescale 1ns / 1ps

module bitmap_page_allocator #(
   parameter int BITMAP_WORDS = 128,
   parameter int PAGE_SHIFT   = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   bpa_req_if.sink                      req_chan,
   bpa_rsp_if.source                    rsp_chan,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [bpa_pkg::PDATA_W-1:0]  pwdata,
   output logic [bpa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int AW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

   bpa_pkg::cfg_type cfg;
   logic             ram_rd_en;
   logic [AW-1:0]    ram_rd_addr;
   logic [31:0]      ram_rd_data;
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [31:0]      ram_wr_data;

   bpa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   bpa_bitmap_ram #(
      .DEPTH  (BITMAP_WORDS),
      .ADDR_W (AW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data)
   );

   bpa_ctrl #(
      .BITMAP_WORDS (BITMAP_WORDS),
      .PAGE_SHIFT   (PAGE_SHIFT),
      .AW           (AW)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data)
   );

endmodule
